// File: src/fog_pkg.sv
package fog_pkg;

    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int SPACING_W  = 16;
    localparam int OFFSET_W   = 24;
    localparam int XMULT_W    = 8;
    localparam int YMULT_W    = 9;
    localparam int ROW_W      = 4;
    localparam int TRI_ROWS   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int SQRT3_W    = 17;
    localparam int TRI_PROD_W = 20;

    // sqrt(3) in Q1.16, rounded to nearest
    localparam logic [SQRT3_W-1:0] SQRT3_Q16 = 17'd113512;
    localparam int                 ROUND_SH  = 16;

    localparam logic [COUNT_W-1:0]   COUNT_RESET   = 7'd1;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd256;

    typedef enum logic [1:0] {
        FORM_V        = 2'd0,
        FORM_DIAMOND  = 2'd1,
        FORM_LINE     = 2'd2,
        FORM_TRIANGLE = 2'd3
    } form_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOLLOWER_COUNT = 2'd0,
        CFG_SPACING        = 2'd1
    } cfg_idx_t;

    // classified item passed from front to back
    typedef struct packed {
        logic                      err;
        logic                      is_tri;
        logic [XMULT_W-1:0]        x_mult;
        logic signed [YMULT_W-1:0] y_mult;
    } cls_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] x;
        logic [OFFSET_W-1:0] y;
        logic                err;
    } res_t;

endpackage

// File: src/fog_fifo.sv
module fog_fifo
    import fog_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      used;
    logic             do_push;
    logic             do_pop;

    assign used    = wr_ptr_reg - rd_ptr_reg;
    assign full    = (used == (AW+1)'(DEPTH));
    assign empty   = (used == '0);
    assign count   = ($clog2(DEPTH+1))'(used);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg[AW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (AW+1)'(do_push);
        rd_ptr_next = rd_ptr_reg + (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= din;
        end
    end

endmodule

// File: src/fog_front.sv
module fog_front
    import fog_pkg::*;
#(
    parameter int MAX_FOLLOWERS = 64
)
(
    input  logic [IDX_W-1:0]   follower_index,
    input  logic [1:0]         formation_code,
    input  logic [COUNT_W-1:0] follower_count,
    output cls_t               cls
);

    logic [XMULT_W-1:0]        xm;
    logic signed [YMULT_W-1:0] ym;
    logic [ROW_W-1:0]          row;
    logic [IDX_W-1:0]          start;
    logic [IDX_W-1:0]          col;
    logic                      err;
    form_t                     form;

    assign form = form_t'(formation_code);
    assign err  = ({1'b0, follower_index} >= follower_count)
                  || (32'(follower_index) >= MAX_FOLLOWERS);

    // triangle row r begins at (r-1)(r+2)/2
    always_comb
    begin
        row   = ROW_W'(1);
        start = '0;
        for (int r = 2; r < TRI_ROWS; r++)
        begin
            if (32'(follower_index) >= ((r - 1) * (r + 2)) / 2)
            begin
                row   = ROW_W'(r);
                start = IDX_W'(((r - 1) * (r + 2)) / 2);
            end
        end
        col = follower_index - start;
    end

    always_comb
    begin
        xm = '0;
        ym = '0;
        case (form)
            FORM_V:
            begin
                // rank reaches 32, so the sum needs six bits
                xm = {1'b0, {1'b0, follower_index[IDX_W-1:1]} + IDX_W'(1), 1'b0};
                ym = follower_index[0] ? $signed({1'b0, xm}) : -$signed({1'b0, xm});
            end
            FORM_DIAMOND:
            begin
                if (follower_index < IDX_W'(2))
                begin
                    xm = XMULT_W'(2);
                    ym = follower_index[0] ? YMULT_W'(2) : -YMULT_W'(2);
                end
                else
                begin
                    xm = {1'b0, follower_index, 1'b0};
                end
            end
            FORM_LINE:
            begin
                xm = {1'b0, follower_index, 1'b0} + XMULT_W'(2);
            end
            FORM_TRIANGLE:
            begin
                xm = XMULT_W'(row);
                ym = $signed({2'b00, col, 1'b0}) - $signed({5'b00000, row});
            end
            default:
            begin
                xm = '0;
                ym = '0;
            end
        endcase
    end

    always_comb
    begin
        cls.err    = err;
        cls.is_tri = !err && (form == FORM_TRIANGLE);
        cls.x_mult = err ? '0 : xm;
        cls.y_mult = err ? '0 : ym;
    end

endmodule

// File: src/fog_back.sv
module fog_back
    import fog_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [SPACING_W-1:0]           spacing,
    input  cls_t                           cls,
    input  logic                           cls_empty,
    output logic                           cls_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_push,
    output res_t                           res
);

    localparam int CNT_W  = $clog2(OUT_DEPTH + 3);
    localparam int PY_W   = YMULT_W + SPACING_W + 1;
    localparam int PRD_W  = TRI_PROD_W + SQRT3_W;

    logic                    s1_v_reg;
    logic                    s1_err_reg;
    logic                    s1_tri_reg;
    logic [OFFSET_W-1:0]     s1_px_reg;
    logic [OFFSET_W-1:0]     s1_py_reg;
    logic                    s2_v_reg;
    res_t                    s2_res_reg;
    logic [CNT_W-1:0]        in_flight;
    logic signed [PY_W-1:0]  py;
    logic [PRD_W-1:0]        tri_prod;
    logic [OFFSET_W-1:0]     x_mag;

    // items already owed a slot in the output queue
    assign in_flight = CNT_W'(out_count) + CNT_W'(s1_v_reg) + CNT_W'(s2_v_reg);
    assign cls_pop   = !cls_empty && (in_flight < CNT_W'(OUT_DEPTH));

    assign py = $signed(cls.y_mult) * $signed({1'b0, spacing});

    assign tri_prod = s1_px_reg[TRI_PROD_W-1:0] * SQRT3_Q16
                      + PRD_W'(1 << (ROUND_SH - 1));
    assign x_mag    = s1_tri_reg ? OFFSET_W'(tri_prod >> ROUND_SH) : s1_px_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cls_pop;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_pop)
        begin
            s1_err_reg <= cls.err;
            s1_tri_reg <= cls.is_tri;
            s1_px_reg  <= OFFSET_W'(cls.x_mult) * OFFSET_W'(spacing);
            s1_py_reg  <= OFFSET_W'(py);
        end
        if (s1_v_reg)
        begin
            s2_res_reg.x   <= -x_mag;
            s2_res_reg.y   <= s1_py_reg;
            s2_res_reg.err <= s1_err_reg;
        end
    end

    assign res_push = s2_v_reg;
    assign res      = s2_res_reg;

endmodule

// File: src/formation_offset_generator.sv
// An accepted item passes through the front queue, the spacing multiply, the sqrt(3) multiply
// and rounding, and the output queue before it shows on the result ports.
// Throughput: one item per cycle; the output queue's free slots, counted against the two
// back-end stages in flight, gate how fast the front queue drains.
// Reset (asynchronous, rst_n low) empties both queues and the back-end stages and
// loads follower_count = 1 and spacing = 256 (1 m).
module formation_offset_generator
    import fog_pkg::*;
#(
    parameter int MAX_FOLLOWERS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [IDX_W-1:0]     follower_index,
    input  logic [1:0]           formation_code,
    output logic                 empty,
    input  logic                 pop,
    output logic [OFFSET_W-1:0]  offset_x,
    output logic [OFFSET_W-1:0]  offset_y,
    output logic                 index_error,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SPACING_W-1:0] cfg_data
);

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    logic [COUNT_W-1:0]           follower_count_reg;
    logic [SPACING_W-1:0]         spacing_reg;
    cls_t                         cls_in;
    cls_t                         cls_out;
    logic                         cls_empty;
    logic                         cls_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic                         res_push;
    res_t                         res_in;
    res_t                         res_out;
    logic                         out_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follower_count_reg <= COUNT_RESET;
            spacing_reg        <= SPACING_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FOLLOWER_COUNT: follower_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_SPACING:        spacing_reg        <= cfg_data;
                default:            ;
            endcase
        end
    end

    fog_front #(
        .MAX_FOLLOWERS(MAX_FOLLOWERS)
    ) u_front (
        .follower_index(follower_index),
        .formation_code(formation_code),
        .follower_count(follower_count_reg),
        .cls           (cls_in)
    );

    fog_fifo #(
        .WIDTH($bits(cls_t)),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (cls_in),
        .full (full),
        .pop  (cls_pop),
        .dout (cls_out),
        .empty(cls_empty),
        .count(mid_count)
    );

    fog_back #(
        .OUT_DEPTH(OUT_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .spacing  (spacing_reg),
        .cls      (cls_out),
        .cls_empty(cls_empty || (mid_count == '0)),
        .cls_pop  (cls_pop),
        .out_count(out_count),
        .res_push (res_push),
        .res      (res_in)
    );

    // credit check in the back end keeps this queue from overflowing
    fog_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .din  (res_in),
        .full (out_full),
        .pop  (pop && !out_full || pop),
        .dout (res_out),
        .empty(empty),
        .count(out_count)
    );

    assign offset_x    = res_out.x;
    assign offset_y    = res_out.y;
    assign index_error = res_out.err;

endmodule
